// ----- hdl/irpd_pkg.sv -----
// shared types, constants and helpers for the ir pulse-distance frame decoder
`timescale 1ns / 1ps

package irpd_pkg;

    // frame length in bits (12 to 32)
    localparam int PAUSE_BITS = 16;
    localparam int CNT_W      = $clog2(PAUSE_BITS + 1);
    // queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PAUSE_W = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    typedef logic [PAUSE_BITS-1:0] frame_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [PAUSE_W-1:0]    pause_t;
    typedef logic [CFG_W-1:0]      cfg_word_t;
    typedef logic [CIDX_W-1:0]     cfg_index_t;

    // register indexes
    localparam cfg_index_t CFG_ONE_LOW   = 3'd0;
    localparam cfg_index_t CFG_ONE_HIGH  = 3'd1;
    localparam cfg_index_t CFG_ZERO_LOW  = 3'd2;
    localparam cfg_index_t CFG_ZERO_HIGH = 3'd3;
    localparam cfg_index_t CFG_GAP_LOW   = 3'd4;
    localparam cfg_index_t CFG_GAP_HIGH  = 3'd5;

    // register reset values
    localparam cfg_word_t RST_ONE_LOW   = 16'd600;
    localparam cfg_word_t RST_ONE_HIGH  = 16'd1000;
    localparam cfg_word_t RST_ZERO_LOW  = 16'd1400;
    localparam cfg_word_t RST_ZERO_HIGH = 16'd1800;
    localparam cfg_word_t RST_GAP_LOW   = 16'd2000;
    localparam cfg_word_t RST_GAP_HIGH  = 16'd4000;

    // result kinds
    localparam logic KIND_DELIVERED    = 1'b0;
    localparam logic KIND_CHECK_FAILED = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BITS = 2'd1,
        MODE_GAP  = 2'd2
    } mode_t;

    // window membership of one pause
    typedef struct packed {
        logic one;
        logic zero;
        logic gap;
    } pause_class_t;

    // window registers as one bundle
    typedef struct packed {
        cfg_word_t one_low;
        cfg_word_t one_high;
        cfg_word_t zero_low;
        cfg_word_t zero_high;
        cfg_word_t gap_low;
        cfg_word_t gap_high;
    } windows_t;

    // exclusive on both ends
    function automatic logic in_window(pause_t p, cfg_word_t lo, cfg_word_t hi);
        return (p > lo) && (p < hi);
    endfunction

    // bits 15..11 against bits 5..1, positions past the frame read zero
    function automatic logic frame_valid(frame_t f);
        logic [31:0] w;
        w = 32'(f);
        return w[15:11] == w[5:1];
    endfunction

    function automatic logic [7:0] message_of(frame_t f);
        return f[8:1];
    endfunction

endpackage

// ----- hdl/irpd_front.sv -----
// front: window registers and pause classification
`timescale 1ns / 1ps

module irpd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  irpd_pkg::cfg_index_t  cfg_index,
    input  irpd_pkg::cfg_word_t   cfg_data,
    input  irpd_pkg::pause_t      pause,
    output irpd_pkg::pause_class_t pause_class
);

    irpd_pkg::windows_t win_reg;
    irpd_pkg::windows_t win_next;

    always_comb begin
        win_next = win_reg;
        if (cfg_valid) begin
            case (cfg_index)
                irpd_pkg::CFG_ONE_LOW:   win_next.one_low   = cfg_data;
                irpd_pkg::CFG_ONE_HIGH:  win_next.one_high  = cfg_data;
                irpd_pkg::CFG_ZERO_LOW:  win_next.zero_low  = cfg_data;
                irpd_pkg::CFG_ZERO_HIGH: win_next.zero_high = cfg_data;
                irpd_pkg::CFG_GAP_LOW:   win_next.gap_low   = cfg_data;
                irpd_pkg::CFG_GAP_HIGH:  win_next.gap_high  = cfg_data;
                default:                 win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.one_low   <= irpd_pkg::RST_ONE_LOW;
            win_reg.one_high  <= irpd_pkg::RST_ONE_HIGH;
            win_reg.zero_low  <= irpd_pkg::RST_ZERO_LOW;
            win_reg.zero_high <= irpd_pkg::RST_ZERO_HIGH;
            win_reg.gap_low   <= irpd_pkg::RST_GAP_LOW;
            win_reg.gap_high  <= irpd_pkg::RST_GAP_HIGH;
        end else begin
            win_reg <= win_next;
        end
    end

    // all three windows in parallel, priority is settled in the back
    always_comb begin
        pause_class.one  = irpd_pkg::in_window(pause, win_reg.one_low, win_reg.one_high);
        pause_class.zero = irpd_pkg::in_window(pause, win_reg.zero_low, win_reg.zero_high);
        pause_class.gap  = irpd_pkg::in_window(pause, win_reg.gap_low, win_reg.gap_high);
    end

endmodule

// ----- hdl/irpd_queue.sv -----
// short queue of classified pauses between front and back
`timescale 1ns / 1ps

module irpd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  irpd_pkg::pause_class_t push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output irpd_pkg::pause_class_t pop_data
);

    irpd_pkg::pause_class_t entry_reg [irpd_pkg::QUEUE_DEPTH];
    logic [irpd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [irpd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [irpd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = count_reg != irpd_pkg::QCNT_W'(irpd_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + irpd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + irpd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + irpd_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - irpd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/irpd_back.sv -----
// back: frame state machine and result register
`timescale 1ns / 1ps

module irpd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  irpd_pkg::pause_class_t in_class,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_message_byte,
    output logic                   m_result_kind
);

    irpd_pkg::mode_t  mode_reg, mode_next;
    irpd_pkg::count_t count_reg, count_next;
    irpd_pkg::frame_t shift_reg, shift_next;
    irpd_pkg::frame_t prev_reg, prev_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_kind_reg, out_kind_next;

    logic             take;
    logic             bit_ok;
    logic             bit_val;
    irpd_pkg::frame_t shifted;
    irpd_pkg::count_t count_inc;
    logic             frame_done;
    logic             repeat_hit;
    logic             emit;

    // a result slot is free when empty or draining this cycle
    assign in_ready = !out_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    // one-window wins over zero-window
    assign bit_ok     = in_class.one || in_class.zero;
    assign bit_val    = in_class.one;
    assign shifted    = {shift_reg[irpd_pkg::PAUSE_BITS-2:0], bit_val};
    assign count_inc  = count_reg + irpd_pkg::CNT_W'(1);
    assign frame_done = count_inc == irpd_pkg::CNT_W'(irpd_pkg::PAUSE_BITS);
    assign repeat_hit = in_class.gap && (shift_reg == prev_reg);

    // next state
    always_comb begin
        mode_next = mode_reg;
        if (take) begin
            case (mode_reg)
                irpd_pkg::MODE_BITS: begin
                    if (!bit_ok) begin
                        mode_next = irpd_pkg::MODE_IDLE;
                    end else if (frame_done) begin
                        mode_next = irpd_pkg::frame_valid(shifted) ? irpd_pkg::MODE_GAP
                                                                   : irpd_pkg::MODE_IDLE;
                    end
                end
                irpd_pkg::MODE_GAP: begin
                    mode_next = irpd_pkg::MODE_IDLE;
                end
                default: begin
                    mode_next = in_class.one ? irpd_pkg::MODE_BITS : irpd_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // datapath and result
    always_comb begin
        count_next    = count_reg;
        shift_next    = shift_reg;
        prev_next     = prev_reg;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        out_kind_next = out_kind_reg;
        if (take) begin
            case (mode_reg)
                irpd_pkg::MODE_BITS: begin
                    if (bit_ok) begin
                        shift_next = shifted;
                        count_next = frame_done ? '0 : count_inc;
                        if (frame_done && !irpd_pkg::frame_valid(shifted)) begin
                            emit          = 1'b1;
                            out_byte_next = irpd_pkg::message_of(shifted);
                            out_kind_next = irpd_pkg::KIND_CHECK_FAILED;
                        end
                    end
                end
                irpd_pkg::MODE_GAP: begin
                    if (repeat_hit) begin
                        prev_next = '0;
                    end else begin
                        prev_next     = shift_reg;
                        emit          = 1'b1;
                        out_byte_next = irpd_pkg::message_of(shift_reg);
                        out_kind_next = irpd_pkg::KIND_DELIVERED;
                    end
                end
                default: begin
                    if (in_class.one) begin
                        count_next = '0;
                        shift_next = '0;
                    end
                end
            endcase
        end
        if (take) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= irpd_pkg::MODE_IDLE;
            count_reg     <= '0;
            shift_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_message_byte = out_byte_reg;
    assign m_result_kind  = out_kind_reg;

endmodule

// ----- hdl/ir_pulse_distance_frame_decoder_unit.sv -----
// top level of the ir pulse-distance frame decoder
`timescale 1ns / 1ps

//  channel  | direction | ports                                   | beat
//  ---------+-----------+-----------------------------------------+---------------------------
//  s_       | in        | s_valid s_ready s_pause_length          | one measured pause
//  m_       | out       | m_valid m_ready m_message_byte          | one result, kind 0 frame,
//           |           | m_result_kind                           | kind 1 check failed
//  cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data  | one window register write
//
//  one pause beat per cycle sustained while m_ready does not stall the result register; each
//  pause beat is first written into the queue, then the state machine steps on it and loads
//  the result register; the rate is set by the single-step state machine in the back, one
//  pause per cycle unless a stalled result register holds the back
//  reset: synchronous active-low aresetn, windows return to their defaults, decoder idle
//  s_ready falls only while the two-entry queue is full; m_ready stalls hold the result
//  register and the back, the front keeps filling the queue meanwhile
module ir_pulse_distance_frame_decoder_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    // pause input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  irpd_pkg::pause_t     s_pause_length,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_message_byte,
    output logic                 m_result_kind,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  irpd_pkg::cfg_index_t cfg_index,
    input  irpd_pkg::cfg_word_t  cfg_data
);

    irpd_pkg::pause_class_t front_class;
    irpd_pkg::pause_class_t q_class;
    logic                   q_valid;
    logic                   q_ready;

    // writes are always taken; the user must issue them only while idle, the block itself does not enforce it
    assign cfg_ready = 1'b1;

    // classify the incoming pause against the windows
    irpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pause       (s_pause_length),
        .pause_class (front_class)
    );

    // decouples s_ready from m_ready
    irpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_class),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_class)
    );

    // frame assembly, check, repeat suppression and the result register
    irpd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_class       (q_class),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_message_byte (m_message_byte),
        .m_result_kind  (m_result_kind)
    );

    // a pushed pause is waiting for the back on the next cycle at the latest
    a_push_fills_queue: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_valid
    ) else $error("queue empty after a pause beat");

    // input stalls only when the queue holds something
    a_stall_means_backlog: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid
    ) else $error("input stalled with an empty queue");

    // a new result appears only after the back stepped on a queued pause
    a_result_from_step: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_valid && q_ready)
    ) else $error("result without a queued pause");

endmodule
